@@ hw/rtl/preemptive_priority_scheduler_macros.svh @@
// assertion macros for the checker file of the scheduler
// each macro expects signals named clk and arst_n in the scope of use
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

@@ hw/rtl/pps_pkg.sv @@
// shared types and constants of the preemptive priority scheduler
// no dependencies
package pps_pkg;

	localparam int TIME_W = 32;
	localparam int ID_W   = 16;
	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRI_W  = 8;

	// action codes
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [ID_W-1:0]  proc_id;
		logic [ARR_W-1:0] arrival;
		logic [BUR_W-1:0] burst;
		logic [PRI_W-1:0] prio;
	} req_t;

	// one word of the process table
	typedef struct packed {
		logic [ID_W-1:0]  proc_id;
		logic [ARR_W-1:0] arrival;
		logic [BUR_W-1:0] burst;
		logic [BUR_W-1:0] remaining;
		logic [PRI_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic              load_error;
		logic              ran;
		logic [ID_W-1:0]   run_id;
		logic              first_run;
		logic [TIME_W-1:0] response_time;
		logic              finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] time_now;
		logic              all_done;
	} result_t;

endpackage

@@ hw/rtl/pps_in_if.sv @@
// request channel of the scheduler: valid, ready and one input item
// no dependencies
interface pps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] proc_id;
	logic [15:0] arrival;
	logic [15:0] burst;
	logic [7:0]  prio;

	modport source (output valid, action, proc_id, arrival, burst, prio, input ready);
	modport sink (input valid, action, proc_id, arrival, burst, prio, output ready);
endinterface

@@ hw/rtl/pps_out_if.sv @@
// result channel of the scheduler: valid, ready and one result item
// no dependencies
interface pps_out_if;
	logic        valid;
	logic        ready;
	logic        load_error;
	logic        ran;
	logic [15:0] run_id;
	logic        first_run;
	logic [31:0] response_time;
	logic        finished;
	logic [31:0] turnaround;
	logic [31:0] waiting;
	logic [31:0] time_now;
	logic        all_done;

	modport source (output valid, load_error, ran, run_id, first_run, response_time,
		finished, turnaround, waiting, time_now, all_done, input ready);
	modport sink (input valid, load_error, ran, run_id, first_run, response_time,
		finished, turnaround, waiting, time_now, all_done, output ready);
endinterface

@@ hw/rtl/pps_table.sv @@
// process table memory: one write port, one read port, registered read data
// depends on pps_pkg
module pps_table #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  pps_pkg::entry_t          wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output pps_pkg::entry_t          rdata
);

	pps_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/pps_ctrl.sv @@
// scheduler sequencer: table scan, pick, write-back, result formation
// depends on pps_pkg; drives the pps_table ports
module pps_ctrl #(
	parameter int MAX_PROCS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  pps_pkg::req_t                in_data,
	output logic                         res_valid,
	input  logic                         res_ready,
	output pps_pkg::result_t             res,
	output logic                         mem_we,
	output logic [$clog2(MAX_PROCS)-1:0] mem_waddr,
	output pps_pkg::entry_t              mem_wdata,
	output logic                         mem_re,
	output logic [$clog2(MAX_PROCS)-1:0] mem_raddr,
	input  pps_pkg::entry_t              mem_rdata
);

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_PROCS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_WRAP,
		ST_OUT
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              entry_cnt_q;
	logic [CNT_W-1:0]              done_cnt_q;
	logic [pps_pkg::TIME_W-1:0]    clock_q;
	logic [MAX_PROCS-1:0]          started_q;
	logic [MAX_PROCS-1:0]          done_q;
	logic [CNT_W-1:0]              issue_q;
	logic                          vld_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          found_q;
	pps_pkg::entry_t               best_q;
	logic [IDX_W-1:0]              best_idx_q;
	pps_pkg::result_t              res_q;

	logic                          accept;
	logic                          full;
	logic                          eligible;
	logic                          better;
	logic [pps_pkg::BUR_W-1:0]     rem_new;
	logic [pps_pkg::BUR_W-1:0]     load_burst;
	logic [pps_pkg::TIME_W-1:0]    clock_nxt;
	logic                          scan_end;
	pps_pkg::entry_t               load_entry;
	pps_pkg::entry_t               upd_entry;
	pps_pkg::result_t              acc_res;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (entry_cnt_q == FULL);
	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;

	assign load_burst = (in_data.burst == '0) ? pps_pkg::BUR_W'(1) : in_data.burst;
	assign load_entry = '{proc_id: in_data.proc_id, arrival: in_data.arrival,
		burst: load_burst, remaining: load_burst, prio: in_data.prio};

	assign rem_new   = (best_q.remaining != '0) ? best_q.remaining - pps_pkg::BUR_W'(1)
		: best_q.remaining;
	assign upd_entry = '{proc_id: best_q.proc_id, arrival: best_q.arrival,
		burst: best_q.burst, remaining: rem_new, prio: best_q.prio};
	assign clock_nxt = (clock_q == '1) ? clock_q : clock_q + pps_pkg::TIME_W'(1);

	// result of an accepted item as it stands before any tick processing
	always_comb begin
		acc_res          = '0;
		acc_res.time_now = clock_q;
		acc_res.all_done = (done_cnt_q == entry_cnt_q);
		case (in_data.action)
			pps_pkg::ACT_LOAD: begin
				if (full) begin
					acc_res.load_error = 1'b1;
				end else begin
					acc_res.all_done = 1'b0;
				end
			end
			pps_pkg::ACT_CLEAR: begin
				acc_res.time_now = '0;
				acc_res.all_done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// table accesses never overlap: loads only in idle, reads only in scan,
	// the write-back only after the scan has drained
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = entry_cnt_q[IDX_W-1:0];
		mem_wdata = load_entry;
		if (state_q == ST_UPDATE) begin
			mem_we    = found_q;
			mem_waddr = best_idx_q;
			mem_wdata = upd_entry;
		end else if (accept && in_data.action == pps_pkg::ACT_LOAD && !full) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re    = (state_q == ST_SCAN) && (issue_q != entry_cnt_q);
	assign mem_raddr = issue_q[IDX_W-1:0];
	assign scan_end  = (issue_q == entry_cnt_q) && !vld_s1;

	// selection: smaller priority wins, then earlier arrival, then lower slot
	assign eligible = !done_q[idx_s1]
		&& ({{(pps_pkg::TIME_W-pps_pkg::ARR_W){1'b0}}, mem_rdata.arrival} <= clock_q);
	assign better = !found_q || (mem_rdata.prio < best_q.prio)
		|| ((mem_rdata.prio == best_q.prio) && (mem_rdata.arrival < best_q.arrival));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			entry_cnt_q <= '0;
			done_cnt_q  <= '0;
			clock_q     <= '0;
			started_q   <= '0;
			done_q      <= '0;
			issue_q     <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q   <= acc_res;
						state_q <= (in_data.action == pps_pkg::ACT_TICK) ? ST_SCAN : ST_OUT;
						case (in_data.action)
							pps_pkg::ACT_LOAD: begin
								if (!full) begin
									started_q[entry_cnt_q[IDX_W-1:0]] <= 1'b0;
									done_q[entry_cnt_q[IDX_W-1:0]]    <= 1'b0;
									entry_cnt_q <= entry_cnt_q + CNT_W'(1);
								end
							end
							pps_pkg::ACT_TICK: begin
								issue_q <= '0;
								found_q <= 1'b0;
							end
							pps_pkg::ACT_CLEAR: begin
								entry_cnt_q <= '0;
								done_cnt_q  <= '0;
								clock_q     <= '0;
								started_q   <= '0;
								done_q      <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					vld_s1 <= mem_re;
					idx_s1 <= issue_q[IDX_W-1:0];
					if (mem_re) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (vld_s1 && eligible && better) begin
						found_q    <= 1'b1;
						best_q     <= mem_rdata;
						best_idx_q <= idx_s1;
					end
					if (scan_end) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					clock_q        <= clock_nxt;
					res_q.time_now <= clock_nxt;
					if (found_q) begin
						res_q.ran    <= 1'b1;
						res_q.run_id <= best_q.proc_id;
						if (!started_q[best_idx_q]) begin
							started_q[best_idx_q] <= 1'b1;
							res_q.first_run       <= 1'b1;
							res_q.response_time   <= clock_q
								- pps_pkg::TIME_W'(best_q.arrival);
						end
						if (rem_new == '0) begin
							done_q[best_idx_q] <= 1'b1;
							done_cnt_q         <= done_cnt_q + CNT_W'(1);
							res_q.finished     <= 1'b1;
							res_q.turnaround   <= clock_nxt
								- pps_pkg::TIME_W'(best_q.arrival);
						end
					end
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					res_q.all_done <= (done_cnt_q == entry_cnt_q);
					if (res_q.finished
						&& (res_q.turnaround > pps_pkg::TIME_W'(best_q.burst))) begin
						res_q.waiting <= res_q.turnaround - pps_pkg::TIME_W'(best_q.burst);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/preemptive_priority_scheduler.sv @@
// preemptive priority scheduler: top level with result output register
// depends on pps_pkg, pps_in_if, pps_out_if, pps_table, pps_ctrl
//
// usage
//   req carries one item: load a process (id, arrival, burst, priority),
//   advance the clock by one tick, or clear the table and the clock
//   rsp returns exactly one result item per request item, in order
//   load and clear need no table scan: their result is formed at acceptance
//   a tick reads the process table once per loaded entry through the single
//   memory read port, one entry per cycle, then passes through the update and
//   wrap states, which set the clock and the result flags
//   one item is in work at a time; req.ready is high while the sequencer idles
//   the output register decouples the sides: a new item is accepted while
//   the previous result still waits for rsp.ready
//   when the receiver stalls with the output register full, the sequencer
//   holds its finished result and takes no new item until it has moved on
//   reset clears the clock, the counts and the started/done flags at once;
//   table words need no clearing, only entries below the count are read
//   saturating clock at the all-ones value; running entries still progress
module preemptive_priority_scheduler #(
	parameter int MAX_PROCS = 16
) (
	input logic       clk,
	input logic       arst_n,
	pps_in_if.sink    req,
	pps_out_if.source rsp
);

	localparam int IDX_W = $clog2(MAX_PROCS);

	pps_pkg::req_t    req_data;
	pps_pkg::result_t res;
	pps_pkg::result_t out_q;
	logic             out_vld_q;
	logic             res_valid;
	logic             res_ready;
	logic             in_ready;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	pps_pkg::entry_t  mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	pps_pkg::entry_t  mem_rdata;

	assign req_data = '{action: req.action, proc_id: req.proc_id, arrival: req.arrival,
		burst: req.burst, prio: req.prio};
	assign req.ready = in_ready;

	// output register takes a result when empty or being drained
	assign res_ready = !out_vld_q || rsp.ready;

	pps_ctrl #(
		.MAX_PROCS(MAX_PROCS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.in_data   (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	pps_table #(
		.DEPTH(MAX_PROCS)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.load_error    = out_q.load_error;
	assign rsp.ran           = out_q.ran;
	assign rsp.run_id        = out_q.run_id;
	assign rsp.first_run     = out_q.first_run;
	assign rsp.response_time = out_q.response_time;
	assign rsp.finished      = out_q.finished;
	assign rsp.turnaround    = out_q.turnaround;
	assign rsp.waiting       = out_q.waiting;
	assign rsp.time_now      = out_q.time_now;
	assign rsp.all_done      = out_q.all_done;

endmodule

@@ hw/rtl/pps_checker.sv @@
// port-level checks of the scheduler, attached to the top level by bind
// depends on preemptive_priority_scheduler_macros.svh
`include "preemptive_priority_scheduler_macros.svh"

module pps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_load_error,
	input logic        rsp_ran,
	input logic        rsp_first_run,
	input logic        rsp_finished,
	input logic [31:0] rsp_turnaround,
	input logic [31:0] rsp_waiting,
	input logic [31:0] rsp_time_now
);

	// a stalled result keeps its clock value
	`PPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_time_now))
	// one item in work at a time
	`PPS_ASSERT_NEXT(a_single_item, req_valid && req_ready, !req_ready)
	// dispatch flags only come with a run and never with a refused load
	`PPS_ASSERT_NOW(a_flags_need_run, rsp_valid && (rsp_first_run || rsp_finished), rsp_ran && !rsp_load_error)
	// waiting is turnaround less burst, so never above turnaround
	`PPS_ASSERT_NOW(a_wait_bound, rsp_valid && rsp_finished, rsp_waiting <= rsp_turnaround)

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_load_error (rsp.load_error),
	.rsp_ran        (rsp.ran),
	.rsp_first_run  (rsp.first_run),
	.rsp_finished   (rsp.finished),
	.rsp_turnaround (rsp.turnaround),
	.rsp_waiting    (rsp.waiting),
	.rsp_time_now   (rsp.time_now)
);
